// ----- src/wmv_pkg.sv -----
// wmv_pkg: shared types and constants for the windowed mean/variance block
// register codes, configuration struct, shared unit modes and status codes
// no dependencies
package wmv_pkg;

	typedef struct packed {
		logic [6:0]  window_len;
		logic [31:0] max_iter;
		logic [19:0] precision_target;
		logic [23:0] t_quantile;
	} cfg_t;

	localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [1:0] REG_MAX_ITER   = 2'd1;
	localparam logic [1:0] REG_PRECISION  = 2'd2;
	localparam logic [1:0] REG_T_QUANTILE = 2'd3;

	localparam logic [6:0]  RST_WINDOW_LEN = 7'd8;
	localparam logic [31:0] RST_MAX_ITER   = 32'd1000;
	localparam logic [19:0] RST_PRECISION  = 20'd3277;
	localparam logic [23:0] RST_T_QUANTILE = 24'd154000;

	localparam logic [1:0] MD_MUL  = 2'd0;
	localparam logic [1:0] MD_DIV  = 2'd1;
	localparam logic [1:0] MD_SQRT = 2'd2;

	localparam logic [1:0] STAT_IDLE  = 2'd0;
	localparam logic [1:0] STAT_CONT  = 2'd1;
	localparam logic [1:0] STAT_DONE  = 2'd2;
	localparam logic [1:0] STAT_MAXIT = 2'd3;

	localparam logic [19:0] REL_ONE = 20'h10000;
	localparam logic [19:0] REL_MAX = 20'hFFFFF;

endpackage

// ----- src/wmv_in_if.sv -----
// wmv_in_if: request channel carrying one sample or clear command
// valid/ready handshake, no dependencies
interface wmv_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [23:0] sample_ticks;

	modport source (output valid, output operation, output sample_ticks, input ready);
	modport sink (input valid, input operation, input sample_ticks, output ready);
endinterface

// ----- src/wmv_out_if.sv -----
// wmv_out_if: result channel with window statistics and stop status
// valid/ready handshake, no dependencies
interface wmv_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [39:0] mean_value;
	logic [55:0] variance_value;
	logic [39:0] half_width;
	logic [19:0] rel_precision;

	modport source (output valid, output status, output mean_value, output variance_value,
		output half_width, output rel_precision, input ready);
	modport sink (input valid, input status, input mean_value, input variance_value,
		input half_width, input rel_precision, output ready);
endinterface

// ----- src/wmv_ram.sv -----
// wmv_ram: generic single write port, single read port ram with registered read
// no dependencies
module wmv_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/wmv_cfg.sv -----
// wmv_cfg: apb-style configuration registers
// depends on wmv_pkg
module wmv_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output wmv_pkg::cfg_t cfg,
	output logic          len_wr
);
	logic       wr;
	logic [1:0] idx;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign len_wr = wr && (idx == wmv_pkg::REG_WINDOW_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.window_len       <= wmv_pkg::RST_WINDOW_LEN;
			cfg.max_iter         <= wmv_pkg::RST_MAX_ITER;
			cfg.precision_target <= wmv_pkg::RST_PRECISION;
			cfg.t_quantile       <= wmv_pkg::RST_T_QUANTILE;
		end else if (wr) begin
			unique case (idx)
				wmv_pkg::REG_WINDOW_LEN: cfg.window_len       <= pwdata[6:0];
				wmv_pkg::REG_MAX_ITER:   cfg.max_iter         <= pwdata;
				wmv_pkg::REG_PRECISION:  cfg.precision_target <= pwdata[19:0];
				default:                 cfg.t_quantile       <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wmv_pkg::REG_WINDOW_LEN: prdata = {25'd0, cfg.window_len};
			wmv_pkg::REG_MAX_ITER:   prdata = cfg.max_iter;
			wmv_pkg::REG_PRECISION:  prdata = {12'd0, cfg.precision_target};
			default:                 prdata = {8'd0, cfg.t_quantile};
		endcase
	end
endmodule

// ----- src/wmv_alu.sv -----
// wmv_alu: one step of the shared add/subtract unit
// shift-add multiply, restoring divide and bitwise square root steps
// depends on wmv_pkg
module wmv_alu #(
	parameter int W = 76
) (
	input  logic [1:0]   mode,
	input  logic [W-1:0] acc,
	input  logic [W-1:0] opa,
	input  logic [W-1:0] opb,
	output logic [W-1:0] acc_nxt,
	output logic [W-1:0] opa_nxt,
	output logic [W-1:0] opb_nxt
);
	logic [W-1:0] ua;
	logic [W-1:0] ub;
	logic         sub;
	logic [W:0]   sum;
	logic [W-1:0] rs;
	logic         ge;

	assign rs  = {acc[W-2:0], opa[W-1]};
	assign sum = {1'b0, ua} + {1'b0, (sub ? ~ub : ub)} + (W+1)'(sub);
	assign ge  = sum[W];

	always_comb begin
		unique case (mode)
			wmv_pkg::MD_MUL: begin
				ua      = acc;
				ub      = opa;
				sub     = 1'b0;
				acc_nxt = opb[0] ? sum[W-1:0] : acc;
				opa_nxt = opa << 1;
				opb_nxt = opb >> 1;
			end
			wmv_pkg::MD_DIV: begin
				ua      = rs;
				ub      = opb;
				sub     = 1'b1;
				acc_nxt = ge ? sum[W-1:0] : rs;
				opa_nxt = {opa[W-2:0], ge};
				opb_nxt = opb;
			end
			default: begin
				ua      = acc;
				ub      = opa | opb;
				sub     = 1'b1;
				acc_nxt = ge ? sum[W-1:0] : acc;
				opa_nxt = ge ? ((opa >> 1) | opb) : (opa >> 1);
				opb_nxt = opb >> 2;
			end
		endcase
	end
endmodule

// ----- src/windowed_mean_variance_stop.sv -----
// windowed_mean_variance_stop: sliding window mean, variance and stop decision
// depends on wmv_pkg, wmv_in_if, wmv_out_if, wmv_ram, wmv_cfg, wmv_alu
//
//   channel   | dir | handshake          | payload
//   samples   | in  | valid/ready        | operation, sample_ticks
//   results   | out | valid/ready        | status, mean, variance, half width, precision
//   apb       | in  | psel/penable/pready| window_len, max_iter, precision_target, t_quantile
//
// a sample is worked through eleven phases by the bit-serial steps of the single shared
// add/subtract unit; the last phase, the precision divide, is skipped when the window sum is zero;
// no new request is taken until the result has moved to the output register
// a clear request skips the unit and goes straight to the output register
// reset is asynchronous; ring slots not yet written since a clear read as zero, no sweep
// a finished result waits in the output register while the next request is taken
module windowed_mean_variance_stop #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	wmv_in_if.sink      samples,
	wmv_out_if.source   results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int SB     = SAMPLE_BITS;
	localparam int AW     = $clog2(WINDOW_MAX);
	localparam int LB     = $clog2(WINDOW_MAX + 1);
	localparam int S1W    = SB + AW;
	localparam int S2W    = 2 * SB + AW;
	localparam int DW     = 2 * SB + 2 * AW;
	localparam int W      = (DW + 16 > 72) ? DW + 16 : 72;
	localparam int CW     = $clog2(W + 1);
	localparam int N_MEAN = S1W + 16;
	localparam int N_VAR  = DW + 8;
	localparam int N_HWD  = DW + 16;
	localparam int N_REL  = 48 + LB;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_WR   = 3'd2;
	localparam logic [2:0] ST_LD   = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_STAT = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [3:0] PH_SQX  = 4'd0;
	localparam logic [3:0] PH_SQO  = 4'd1;
	localparam logic [3:0] PH_LS2  = 4'd2;
	localparam logic [3:0] PH_S1S  = 4'd3;
	localparam logic [3:0] PH_MEAN = 4'd4;
	localparam logic [3:0] PH_VAR  = 4'd5;
	localparam logic [3:0] PH_HWD  = 4'd6;
	localparam logic [3:0] PH_SQRT = 4'd7;
	localparam logic [3:0] PH_TQ   = 4'd8;
	localparam logic [3:0] PH_HL   = 4'd9;
	localparam logic [3:0] PH_REL  = 4'd10;

	wmv_pkg::cfg_t cfg;
	logic          len_wr;

	logic [2:0]      state_q;
	logic [3:0]      ph_q;
	logic [1:0]      mode_q;
	logic [CW-1:0]   cnt_q;
	logic [W-1:0]    acc_q, opa_q, opb_q;
	logic [W-1:0]    acc_nxt, opa_nxt, opb_nxt;

	logic [AW-1:0]   wpos_q;
	logic [31:0]     count_q;
	logic [S1W-1:0]  sum_q;
	logic [S2W-1:0]  sq_q;

	logic [SB-1:0]   x_q, old_q;
	logic [2*SB-1:0] px_q;
	logic [2*LB-1:0] llm_q;
	logic [3*LB-1:0] lll_q;
	logic [DW-1:0]   d_q;
	logic [63:0]     tmp_q;

	logic [1:0]      st_r_q;
	logic [39:0]     mean_r_q;
	logic [55:0]     var_r_q;
	logic [39:0]     hw_r_q;
	logic [19:0]     rel_r_q;

	logic            ovalid_q;
	logic [1:0]      ost_q;
	logic [39:0]     omean_q;
	logic [55:0]     ovar_q;
	logic [39:0]     ohw_q;
	logic [19:0]     orel_q;

	logic [LB-1:0]   len;
	logic [AW-1:0]   rd_addr;
	logic [AW:0]     wpos_inc;
	logic [SB-1:0]   ring_rdata;
	logic [SB-1:0]   old_w;
	logic            ring_we;
	logic [DW-1:0]   sq_b;

	wmv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.len_wr  (len_wr)
	);

	wmv_ram #(.WIDTH(SB), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wpos_q),
		.wdata (x_q),
		.raddr (rd_addr),
		.rdata (ring_rdata)
	);

	wmv_alu #(.W(W)) u_alu (
		.mode    (mode_q),
		.acc     (acc_q),
		.opa     (opa_q),
		.opb     (opb_q),
		.acc_nxt (acc_nxt),
		.opa_nxt (opa_nxt),
		.opb_nxt (opb_nxt)
	);

	always_comb begin
		if (cfg.window_len < 7'd2) begin
			len = LB'(2);
		end else if (32'(cfg.window_len) > 32'(WINDOW_MAX)) begin
			len = LB'(WINDOW_MAX);
		end else begin
			len = LB'(cfg.window_len);
		end
	end

	assign rd_addr  = (32'(wpos_q) >= 32'(len)) ? '0 : wpos_q;
	assign wpos_inc = {1'b0, wpos_q} + 1'b1;
	assign old_w    = (count_q >= 32'(len)) ? ring_rdata : '0;
	assign ring_we  = (state_q == ST_WR);
	assign sq_b     = acc_q[DW-1:0];

	assign samples.ready          = (state_q == ST_IDLE);
	assign results.valid          = ovalid_q;
	assign results.status         = ost_q;
	assign results.mean_value     = omean_q;
	assign results.variance_value = ovar_q;
	assign results.half_width     = ohw_q;
	assign results.rel_precision  = orel_q;

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ph_q     <= PH_SQX;
			wpos_q   <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				ovalid_q <= 1'b0;
			end
			if (len_wr) begin
				wpos_q  <= '0;
				count_q <= '0;
				sum_q   <= '0;
				sq_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						if (samples.operation) begin
							wpos_q   <= '0;
							count_q  <= '0;
							sum_q    <= '0;
							sq_q     <= '0;
							st_r_q   <= wmv_pkg::STAT_IDLE;
							mean_r_q <= '0;
							var_r_q  <= '0;
							hw_r_q   <= '0;
							rel_r_q  <= wmv_pkg::REL_ONE;
							state_q  <= ST_OUT;
						end else begin
							x_q     <= SB'(samples.sample_ticks);
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					wpos_q  <= rd_addr;
					llm_q   <= (2*LB)'(len) * (2*LB)'(len - 1'b1);
					state_q <= ST_WR;
				end
				ST_WR: begin
					old_q   <= old_w;
					sum_q   <= sum_q - S1W'(old_w) + S1W'(x_q);
					wpos_q  <= (32'(wpos_inc) >= 32'(len)) ? '0 : wpos_inc[AW-1:0];
					count_q <= (count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1;
					lll_q   <= (3*LB)'(len) * (3*LB)'(llm_q);
					ph_q    <= PH_SQX;
					state_q <= ST_LD;
				end
				ST_LD: begin
					acc_q   <= '0;
					state_q <= ST_RUN;
					unique case (ph_q)
						PH_SQX: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(x_q);
							opb_q  <= W'(x_q);
							cnt_q  <= CW'(SB);
						end
						PH_SQO: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(old_q);
							opb_q  <= W'(old_q);
							cnt_q  <= CW'(SB);
						end
						PH_LS2: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(sq_q);
							opb_q  <= W'(len);
							cnt_q  <= CW'(LB);
						end
						PH_S1S: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(sum_q);
							opb_q  <= W'(sum_q);
							cnt_q  <= CW'(S1W);
						end
						PH_MEAN: begin
							mode_q <= wmv_pkg::MD_DIV;
							opa_q  <= W'({sum_q, 16'd0}) << (W - N_MEAN);
							opb_q  <= W'(len);
							cnt_q  <= CW'(N_MEAN);
						end
						PH_VAR: begin
							mode_q <= wmv_pkg::MD_DIV;
							opa_q  <= W'({d_q, 8'd0}) << (W - N_VAR);
							opb_q  <= W'(llm_q);
							cnt_q  <= CW'(N_VAR);
						end
						PH_HWD: begin
							mode_q <= wmv_pkg::MD_DIV;
							opa_q  <= W'({d_q, 16'd0}) << (W - N_HWD);
							opb_q  <= W'(lll_q);
							cnt_q  <= CW'(N_HWD);
						end
						PH_SQRT: begin
							mode_q <= wmv_pkg::MD_SQRT;
							acc_q  <= W'(tmp_q);
							opa_q  <= '0;
							opb_q  <= W'(1) << 62;
							cnt_q  <= CW'(32);
						end
						PH_TQ: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(tmp_q[31:0]);
							opb_q  <= W'(cfg.t_quantile);
							cnt_q  <= CW'(24);
						end
						PH_HL: begin
							mode_q <= wmv_pkg::MD_MUL;
							opa_q  <= W'(hw_r_q);
							opb_q  <= W'(len);
							cnt_q  <= CW'(LB);
						end
						default: begin
							mode_q <= wmv_pkg::MD_DIV;
							opa_q  <= W'({tmp_q[40+LB-1:0], 8'd0}) << (W - N_REL);
							opb_q  <= W'(sum_q);
							cnt_q  <= CW'(N_REL);
						end
					endcase
				end
				ST_RUN: begin
					acc_q <= acc_nxt;
					opa_q <= opa_nxt;
					opb_q <= opb_nxt;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_LD;
					unique case (ph_q)
						PH_SQX: begin
							px_q <= acc_q[2*SB-1:0];
							ph_q <= PH_SQO;
						end
						PH_SQO: begin
							sq_q <= sq_q - S2W'(acc_q[2*SB-1:0]) + S2W'(px_q);
							ph_q <= PH_LS2;
						end
						PH_LS2: begin
							d_q  <= acc_q[DW-1:0];
							ph_q <= PH_S1S;
						end
						PH_S1S: begin
							d_q  <= (d_q > sq_b) ? d_q - sq_b : '0;
							ph_q <= PH_MEAN;
						end
						PH_MEAN: begin
							mean_r_q <= (|opa_q[W-1:40]) ? '1 : opa_q[39:0];
							ph_q     <= PH_VAR;
						end
						PH_VAR: begin
							var_r_q <= (|opa_q[W-1:56]) ? '1 : opa_q[55:0];
							ph_q    <= PH_HWD;
						end
						PH_HWD: begin
							tmp_q <= (|opa_q[W-1:64]) ? '1 : opa_q[63:0];
							ph_q  <= PH_SQRT;
						end
						PH_SQRT: begin
							tmp_q <= 64'(opa_q[31:0]);
							ph_q  <= PH_TQ;
						end
						PH_TQ: begin
							hw_r_q <= acc_q[55:16];
							ph_q   <= PH_HL;
						end
						PH_HL: begin
							tmp_q <= 64'(acc_q[40+LB-1:0]);
							if (sum_q == '0) begin
								rel_r_q <= wmv_pkg::REL_MAX;
								state_q <= ST_STAT;
							end else begin
								ph_q <= PH_REL;
							end
						end
						default: begin
							rel_r_q <= (|opa_q[W-1:20]) ? wmv_pkg::REL_MAX : opa_q[19:0];
							state_q <= ST_STAT;
						end
					endcase
				end
				ST_STAT: begin
					if (count_q < 32'(len)) begin
						st_r_q <= wmv_pkg::STAT_CONT;
					end else if (rel_r_q <= cfg.precision_target) begin
						st_r_q <= wmv_pkg::STAT_DONE;
					end else if (count_q >= cfg.max_iter) begin
						st_r_q <= wmv_pkg::STAT_MAXIT;
					end else begin
						st_r_q <= wmv_pkg::STAT_CONT;
					end
					state_q <= ST_OUT;
				end
				default: begin
					if (!ovalid_q || results.ready) begin
						ovalid_q <= 1'b1;
						ost_q    <= st_r_q;
						omean_q  <= mean_r_q;
						ovar_q   <= var_r_q;
						ohw_q    <= hw_r_q;
						orel_q   <= rel_r_q;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule

// ----- src/wmv_chk.sv -----
// wmv_chk: port-level checks for windowed_mean_variance_stop, with bind
// depends on wmv_pkg
module wmv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [39:0] mean_value,
	input logic [19:0] rel_precision
);
	// result held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	// busy after each request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after request");

	// clear result
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == wmv_pkg::STAT_IDLE |->
		mean_value == 40'd0 && rel_precision == wmv_pkg::REL_ONE)
		else $error("bad clear result");

	// zero mean means saturated precision
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wmv_pkg::STAT_IDLE && mean_value == 40'd0 |->
		rel_precision == wmv_pkg::REL_MAX)
		else $error("zero mean without saturated precision");
endmodule

bind windowed_mean_variance_stop wmv_chk u_wmv_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.status        (results.status),
	.mean_value    (results.mean_value),
	.rel_precision (results.rel_precision)
);
